FILE: hw/rtl/mieu_pkg.sv
`timescale 1ns / 1ps
package mieu_pkg;

	localparam int WORD_BITS = 32;
	localparam int SHAMT_BITS = 5;

	typedef enum logic [4:0] {
		ACT_LI    = 5'd0,
		ACT_ADD   = 5'd1,
		ACT_ADDU  = 5'd2,
		ACT_ADDI  = 5'd3,
		ACT_ADDIU = 5'd4,
		ACT_SUB   = 5'd5,
		ACT_SUBU  = 5'd6,
		ACT_MUL   = 5'd7,
		ACT_MULT  = 5'd8,
		ACT_DIV   = 5'd9,
		ACT_AND   = 5'd10,
		ACT_OR    = 5'd11,
		ACT_ANDI  = 5'd12,
		ACT_ORI   = 5'd13,
		ACT_XOR   = 5'd14,
		ACT_SLL   = 5'd15,
		ACT_SRL   = 5'd16,
		ACT_READ  = 5'd17
	} action_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;     // latch the accepted instruction
		logic read_ops;    // register-file read of both sources
		logic execute;     // ALU op or mul/div start
		logic step;        // one iteration of the multiply or divide unit
		logic finish;      // write back and load the output register
	} mieu_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic long_op;     // the op uses the iterative unit
		logic iter_done;   // the iterative unit has finished its last step
	} mieu_stat_t;

endpackage

FILE: hw/rtl/mieu_if.sv
`timescale 1ns / 1ps
interface mieu_in_if;
	logic        valid;
	logic        ready;
	logic [4:0]  action;
	logic [4:0]  dest_index;
	logic [4:0]  src_a_index;
	logic [4:0]  src_b_index;
	logic signed [31:0] immediate;

	modport source (output valid, action, dest_index, src_a_index, src_b_index, immediate,
		input ready);
	modport sink (input valid, action, dest_index, src_a_index, src_b_index, immediate,
		output ready);
endinterface

interface mieu_out_if;
	logic        valid;
	logic        ready;
	logic signed [31:0] value;
	logic signed [31:0] hi_value;
	logic signed [31:0] lo_value;
	logic        divide_by_zero;

	modport source (output valid, value, hi_value, lo_value, divide_by_zero, input ready);
	modport sink (input valid, value, hi_value, lo_value, divide_by_zero, output ready);
endinterface

FILE: hw/rtl/mieu_ctrl.sv
`timescale 1ns / 1ps
module mieu_ctrl
	import mieu_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	input  mieu_stat_t stat,
	output mieu_cmd_t  cmd
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_READ = 4'b0010,
		ST_EXEC = 4'b0100,
		ST_ITER = 4'b1000
	} state_t;

	state_t state_q;
	logic   out_valid_q;

	// The output register frees once its transaction completes.
	logic out_free;
	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	// Command decode.
	always_comb begin
		cmd = '0;
		cmd.capture = in_valid && in_ready;
		unique case (state_q)
			ST_READ: cmd.read_ops = 1'b1;
			ST_EXEC: begin
				cmd.execute = 1'b1;
				cmd.finish = !stat.long_op && out_free;
			end
			ST_ITER: begin
				cmd.step = !stat.iter_done;
				cmd.finish = stat.iter_done && out_free;
			end
			default: ;
		endcase
	end

	// State sequence.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.finish)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: if (cmd.capture) state_q <= ST_READ;
				ST_READ: state_q <= ST_EXEC;
				ST_EXEC: begin
					if (stat.long_op)
						state_q <= ST_ITER;
					else if (out_free)
						state_q <= ST_IDLE;
				end
				ST_ITER: if (cmd.finish) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

FILE: hw/rtl/mieu_dpath.sv
`timescale 1ns / 1ps
module mieu_dpath
	import mieu_pkg::*;
#(
	parameter int REGISTER_COUNT = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  mieu_cmd_t         cmd,
	output mieu_stat_t        stat,
	input  logic [4:0]        in_action,
	input  logic [4:0]        in_dest,
	input  logic [4:0]        in_src_a,
	input  logic [4:0]        in_src_b,
	input  logic [31:0]       in_imm,
	output logic [31:0]       value,
	output logic [31:0]       hi_value,
	output logic [31:0]       lo_value,
	output logic              divide_by_zero
);

	localparam int IDX_BITS = (REGISTER_COUNT > 1) ? $clog2(REGISTER_COUNT) : 1;

	logic [4:0]  action_q, dest_q, src_a_q, src_b_q;
	logic [31:0] imm_q;
	logic [31:0] a_q, b_q;
	logic [31:0] hi_q, lo_q;
	logic [31:0] res_q;
	logic        dbz_q;
	logic [5:0]  count_q;
	logic        is_div_q;
	logic        neg_q, neg_rem_q;
	logic [63:0] acc_q;    // product, or remainder:quotient for divide
	logic [31:0] mcand_q;

	// Register file with per-entry valid bits standing in for the all-zero reset.
	logic [31:0] rf_mem [REGISTER_COUNT];
	logic [REGISTER_COUNT-1:0] rf_valid_q;
	logic [31:0] rda_q, rdb_q;
	logic        rda_ok_q, rdb_ok_q;

	// Capture the instruction.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			action_q <= in_action;
			dest_q <= in_dest;
			src_a_q <= in_src_a;
			src_b_q <= in_src_b;
			imm_q <= in_imm;
		end
	end

	// Registered reads of both sources.
	always_ff @(posedge clk) begin
		if (cmd.read_ops) begin
			rda_q <= rf_mem[IDX_BITS'(src_a_q)];
			rdb_q <= rf_mem[IDX_BITS'(src_b_q)];
			rda_ok_q <= (32'(src_a_q) < 32'(REGISTER_COUNT))
				&& rf_valid_q[IDX_BITS'(src_a_q)];
			rdb_ok_q <= (32'(src_b_q) < 32'(REGISTER_COUNT))
				&& rf_valid_q[IDX_BITS'(src_b_q)];
		end
	end

	logic [31:0] a, b;
	assign a = rda_ok_q ? rda_q : '0;
	assign b = rdb_ok_q ? rdb_q : '0;

	logic long_op;
	assign long_op = (action_q == ACT_MUL) || (action_q == ACT_MULT)
		|| ((action_q == ACT_DIV) && (b != '0));
	assign stat.long_op = long_op;
	assign stat.iter_done = (count_q == 6'd32);

	// Combinational ALU.
	logic [31:0] alu;
	logic [SHAMT_BITS-1:0] shamt;
	assign shamt = imm_q[SHAMT_BITS-1:0];
	always_comb begin
		unique case (action_q)
			ACT_LI: alu = imm_q;
			ACT_ADD, ACT_ADDU: alu = a + b;
			ACT_ADDI, ACT_ADDIU: alu = a + imm_q;
			ACT_SUB, ACT_SUBU: alu = a - b;
			ACT_AND: alu = a & b;
			ACT_OR: alu = a | b;
			ACT_ANDI: alu = a & imm_q;
			ACT_ORI: alu = a | imm_q;
			ACT_XOR: alu = a ^ b;
			ACT_SLL: alu = a << shamt;
			ACT_SRL: alu = a >> shamt;
			ACT_READ: alu = a;
			default: alu = '0;
		endcase
	end

	logic writes;
	assign writes = !((action_q == ACT_MULT) || (action_q == ACT_DIV)
		|| (action_q == ACT_READ) || (action_q > ACT_READ));

	// Magnitudes for the iterative unit.
	logic [31:0] mag_a, mag_b;
	logic        signed_op;
	assign signed_op = (action_q != ACT_MUL);
	assign mag_a = (signed_op && a[31]) ? (-a) : a;
	assign mag_b = (signed_op && b[31]) ? (-b) : b;

	// Shift-add multiply and restoring divide, one bit per step.
	logic [32:0] sub_try;
	assign sub_try = {1'b0, acc_q[62:31]} - {1'b0, mcand_q};
	logic [32:0] add_sum;
	assign add_sum = {1'b0, acc_q[63:32]} + (acc_q[0] ? {1'b0, mcand_q} : 33'd0);

	logic [63:0] mag_res, sres;
	assign mag_res = acc_q;
	always_comb begin
		if (is_div_q)
			sres = {neg_rem_q ? -mag_res[63:32] : mag_res[63:32],
				neg_q ? -mag_res[31:0] : mag_res[31:0]};
		else
			sres = neg_q ? -mag_res : mag_res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.execute && long_op) begin
			count_q <= '0;
		end else if (cmd.step) begin
			count_q <= count_q + 6'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.execute && long_op) begin
			is_div_q <= (action_q == ACT_DIV);
			mcand_q <= mag_b;
			acc_q <= {32'd0, mag_a};
			neg_q <= signed_op && (a[31] ^ b[31]);
			neg_rem_q <= a[31];
		end else if (cmd.step) begin
			if (is_div_q) begin
				if (!sub_try[32])
					acc_q <= {sub_try[31:0], acc_q[30:0], 1'b1};
				else
					acc_q <= {acc_q[62:0], 1'b0};
			end else begin
				acc_q <= {add_sum, acc_q[31:1]};
			end
		end
	end

	// Write back, hi/lo and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rf_valid_q <= '0;
			hi_q <= '0;
			lo_q <= '0;
		end else if (cmd.finish) begin
			if (action_q == ACT_MULT || (action_q == ACT_DIV && b != '0)) begin
				hi_q <= sres[63:32];
				lo_q <= sres[31:0];
			end
			if (writes && 32'(dest_q) < 32'(REGISTER_COUNT))
				rf_valid_q[IDX_BITS'(dest_q)] <= 1'b1;
		end
	end

	logic [31:0] wval;
	assign wval = (action_q == ACT_MUL) ? sres[31:0] : alu;

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			if (writes && 32'(dest_q) < 32'(REGISTER_COUNT))
				rf_mem[IDX_BITS'(dest_q)] <= wval;
			res_q <= wval;
			dbz_q <= (action_q == ACT_DIV) && (b == '0);
		end
	end

	assign value = res_q;
	assign hi_value = hi_q;
	assign lo_value = lo_q;
	assign divide_by_zero = dbz_q;

endmodule

FILE: hw/rtl/mips_integer_execute_unit.sv
`timescale 1ns / 1ps
// Integer execute unit with a register file and hi/lo registers.
// Input channel in: one decoded instruction per transaction (action, register
// indexes, immediate). Output channel out: one result per instruction with the
// value written or read, hi and lo after the instruction and a divide-by-zero
// flag.
// One instruction is in flight at a time. ALU operations pass through capture,
// register-file read and execute, and the result waits until the output
// register is free. mul, mult and a div with a nonzero divisor run a shared
// one-bit-per-cycle multiply/divide unit. The next instruction is accepted the
// cycle after the result is loaded into the output register, so a waiting
// result does not block the next instruction's read and execute; it only holds
// the write-back while the receiver stalls.
// Reset clears the control state, hi, lo and the register-file valid bits, so
// every register reads as zero until written; no clearing pass is needed.
// A stalled receiver keeps the result stable in the output register.
module mips_integer_execute_unit
	import mieu_pkg::*;
#(
	parameter int REGISTER_COUNT = 32
) (
	input  logic clk,
	input  logic arst_n,
	mieu_in_if.sink    in,
	mieu_out_if.source out
);

	mieu_cmd_t  cmd;
	mieu_stat_t stat;

	mieu_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in.valid),
		.in_ready  (in.ready),
		.out_valid (out.valid),
		.out_ready (out.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	mieu_dpath #(
		.REGISTER_COUNT (REGISTER_COUNT)
	) u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.in_action      (in.action),
		.in_dest        (in.dest_index),
		.in_src_a       (in.src_a_index),
		.in_src_b       (in.src_b_index),
		.in_imm         (in.immediate),
		.value          (out.value),
		.hi_value       (out.hi_value),
		.lo_value       (out.lo_value),
		.divide_by_zero (out.divide_by_zero)
	);

endmodule

FILE: sim/mieu_checker.sv
`timescale 1ns / 1ps
module mieu_checker
	import mieu_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	mieu_in_if.sink   in,
	mieu_out_if.sink  out,
	output int        error_count,
	output int        pending_count
);

	typedef struct {
		logic [31:0] value;
		logic [31:0] hi_value;
		logic [31:0] lo_value;
		logic        divide_by_zero;
	} alu_result_t;

	logic [31:0] gpr_shadow [32];
	logic [31:0] hi_shadow;
	logic [31:0] lo_shadow;
	alu_result_t expected_results [$];

	assign pending_count = expected_results.size();

	// Compute the result of one instruction and update the shadow state.
	function automatic alu_result_t execute_instruction(logic [4:0] act, logic [4:0] rd,
			logic [4:0] ra, logic [4:0] rb, logic [31:0] imm);
		alu_result_t r;
		logic [31:0] a;
		logic [31:0] b;
		logic signed [63:0] prod;
		logic signed [31:0] sa;
		logic signed [31:0] sb;
		logic writes;
		a = gpr_shadow[ra];
		b = gpr_shadow[rb];
		sa = a;
		sb = b;
		r.value = '0;
		r.divide_by_zero = 1'b0;
		writes = 1'b1;
		case (act)
			ACT_LI: r.value = imm;
			ACT_ADD, ACT_ADDU: r.value = a + b;
			ACT_ADDI, ACT_ADDIU: r.value = a + imm;
			ACT_SUB, ACT_SUBU: r.value = a - b;
			ACT_MUL: r.value = a * b;
			ACT_MULT: begin
				prod = 64'(sa) * 64'(sb);
				hi_shadow = prod[63:32];
				lo_shadow = prod[31:0];
				writes = 1'b0;
			end
			ACT_DIV: begin
				writes = 1'b0;
				if (b == 0) begin
					r.divide_by_zero = 1'b1;
				end else if (a == 32'h8000_0000 && b == 32'hffff_ffff) begin
					// The most negative value over minus one wraps.
					lo_shadow = 32'h8000_0000;
					hi_shadow = '0;
				end else begin
					lo_shadow = sa / sb;
					hi_shadow = sa % sb;
				end
			end
			ACT_AND: r.value = a & b;
			ACT_OR: r.value = a | b;
			ACT_ANDI: r.value = a & imm;
			ACT_ORI: r.value = a | imm;
			ACT_XOR: r.value = a ^ b;
			ACT_SLL: r.value = a << imm[4:0];
			ACT_SRL: r.value = a >> imm[4:0];
			ACT_READ: begin
				r.value = a;
				writes = 1'b0;
			end
			default: writes = 1'b0;
		endcase
		if (writes)
			gpr_shadow[rd] = r.value;
		r.hi_value = hi_shadow;
		r.lo_value = lo_shadow;
		return r;
	endfunction

	// Predict on each input transaction and compare each output transaction.
	always @(posedge clk or negedge arst_n) begin
		alu_result_t exp_r;
		if (!arst_n) begin
			foreach (gpr_shadow[i])
				gpr_shadow[i] = '0;
			hi_shadow = '0;
			lo_shadow = '0;
			expected_results.delete();
			error_count = 0;
		end else begin
			if (in.valid && in.ready)
				expected_results.insert(expected_results.size(),
					execute_instruction(in.action, in.dest_index,
					in.src_a_index, in.src_b_index, in.immediate));
			if (out.valid && out.ready) begin
				if (expected_results.size() == 0) begin
					$error("unexpected result transaction");
					error_count++;
				end else begin
					exp_r = expected_results.pop_front();
					if (out.value !== exp_r.value) begin
						$error("value: expected %h, got %h", exp_r.value, out.value);
						error_count++;
					end
					if (out.hi_value !== exp_r.hi_value) begin
						$error("hi_value: expected %h, got %h", exp_r.hi_value, out.hi_value);
						error_count++;
					end
					if (out.lo_value !== exp_r.lo_value) begin
						$error("lo_value: expected %h, got %h", exp_r.lo_value, out.lo_value);
						error_count++;
					end
					if (out.divide_by_zero !== exp_r.divide_by_zero) begin
						$error("divide_by_zero: expected %b, got %b", exp_r.divide_by_zero,
							out.divide_by_zero);
						error_count++;
					end
				end
			end
		end
	end

endmodule

FILE: sim/mips_integer_execute_unit_tb.sv
`timescale 1ns / 1ps
module mips_integer_execute_unit_tb
	import mieu_pkg::*;
;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int error_count;
	int pending_count;
	bit sender_done = 1'b0;
	bit hold_sink = 1'b0;

	mieu_in_if  in_ch ();
	mieu_out_if out_ch ();

	mips_integer_execute_unit u_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.in    (in_ch.sink),
		.out   (out_ch.source)
	);

	mieu_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.in           (in_ch.sink),
		.out          (out_ch.sink),
		.error_count  (error_count),
		.pending_count(pending_count)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	initial begin
		in_ch.valid = 1'b0;
		in_ch.action = '0;
		in_ch.dest_index = '0;
		in_ch.src_a_index = '0;
		in_ch.src_b_index = '0;
		in_ch.immediate = '0;
		out_ch.ready = 1'b0;
	end

	// Often no gap, often a short one, now and then a long one.
	function automatic int gap_length();
		int p;
		p = $urandom_range(0, 99);
		if (p < 50)
			return 0;
		if (p < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// Offer one instruction and wait until it is accepted.
	task automatic send_instruction(logic [4:0] act, logic [4:0] rd, logic [4:0] ra,
			logic [4:0] rb, logic [31:0] imm);
		int gap;
		gap = gap_length();
		repeat (gap) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.action <= act;
		in_ch.dest_index <= rd;
		in_ch.src_a_index <= ra;
		in_ch.src_b_index <= rb;
		in_ch.immediate <= imm;
		do
			@(posedge clk);
		while (!in_ch.ready);
	endtask

	// Random operand value with a bias toward the edges.
	function automatic logic [31:0] operand_value();
		case ($urandom_range(0, 7))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'hffff_ffff;
			3: return 32'(signed'($urandom_range(0, 8)) - 4);
			default: return $urandom;
		endcase
	endfunction

	// Receiver: random stalls, plus one long hold-off on request.
	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			if (hold_sink) begin
				out_ch.ready <= 1'b0;
				repeat (400) @(posedge clk);
				hold_sink = 1'b0;
			end
			gap = gap_length();
			if (gap > 0) begin
				out_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
			@(posedge clk);
		end
	end

	// Stimulus: directed corner cases, then random instructions.
	initial begin
		action_t act;
		logic [4:0] rd;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Load edge values, then run every operation on them.
		send_instruction(ACT_LI, 5'd1, 5'd0, 5'd0, 32'h8000_0000);
		send_instruction(ACT_LI, 5'd2, 5'd0, 5'd0, 32'hffff_ffff);
		send_instruction(ACT_LI, 5'd3, 5'd0, 5'd0, 32'h7fff_ffff);
		send_instruction(ACT_DIV, 5'd0, 5'd1, 5'd2, 32'd0);
		send_instruction(ACT_DIV, 5'd0, 5'd3, 5'd4, 32'd0);
		send_instruction(ACT_MULT, 5'd0, 5'd1, 5'd1, 32'd0);
		send_instruction(ACT_MULT, 5'd0, 5'd3, 5'd2, 32'd0);
		send_instruction(ACT_MUL, 5'd5, 5'd3, 5'd3, 32'd0);
		send_instruction(ACT_ADD, 5'd6, 5'd3, 5'd3, 32'd0);
		send_instruction(ACT_ADDU, 5'd6, 5'd1, 5'd2, 32'd0);
		send_instruction(ACT_ADDI, 5'd7, 5'd3, 5'd0, 32'd1);
		send_instruction(ACT_ADDIU, 5'd7, 5'd1, 5'd0, 32'hffff_ffff);
		send_instruction(ACT_SUB, 5'd8, 5'd1, 5'd3, 32'd0);
		send_instruction(ACT_SUBU, 5'd8, 5'd4, 5'd2, 32'd0);
		send_instruction(ACT_AND, 5'd9, 5'd2, 5'd3, 32'd0);
		send_instruction(ACT_OR, 5'd9, 5'd1, 5'd3, 32'd0);
		send_instruction(ACT_ANDI, 5'd10, 5'd2, 5'd0, 32'h5555_aaaa);
		send_instruction(ACT_ORI, 5'd10, 5'd0, 5'd0, 32'haaaa_5555);
		send_instruction(ACT_XOR, 5'd11, 5'd2, 5'd3, 32'd0);
		send_instruction(ACT_SLL, 5'd12, 5'd2, 5'd0, 32'hffff_ffff);
		send_instruction(ACT_SRL, 5'd13, 5'd2, 5'd0, 32'h0000_0021);
		send_instruction(ACT_LI, 5'd0, 5'd0, 5'd0, 32'h1234_5678);
		send_instruction(ACT_READ, 5'd31, 5'd0, 5'd31, 32'd0);
		send_instruction(action_t'(5'd31), 5'd31, 5'd31, 5'd31, 32'hffff_ffff);
		send_instruction(action_t'(5'd18), 5'd1, 5'd1, 5'd1, 32'd0);

		// Pause until every expected result has come.
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_count != 0) @(posedge clk);

		for (int n = 0; n < 450; n++) begin
			if (n == 150)
				hold_sink = 1'b1;
			rd = 5'($urandom_range(0, 31));
			if ($urandom_range(0, 9) < 3 || n < 40) begin
				act = ACT_LI;
			end else if ($urandom_range(0, 29) == 0) begin
				act = action_t'($urandom_range(18, 31));
			end else begin
				act = action_t'($urandom_range(1, 17));
			end
			send_instruction(act, rd, 5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)),
				act == ACT_LI ? operand_value() : 32'($urandom));
		end
		in_ch.valid <= 1'b0;
		sender_done = 1'b1;
	end

	// Verdict once everything has drained.
	initial begin
		wait (sender_done);
		@(posedge clk);
		while (pending_count != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (error_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

FILE: mips_integer_execute_unit.f
hw/rtl/mieu_pkg.sv
hw/rtl/mieu_if.sv
hw/rtl/mieu_ctrl.sv
hw/rtl/mieu_dpath.sv
hw/rtl/mips_integer_execute_unit.sv
sim/mieu_checker.sv
sim/mips_integer_execute_unit_tb.sv
